// ===== hw/rtl/jlst_pkg.sv =====
package jlst_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam int POS_FRAC  = 32;
  localparam int POS_SHIFT = POS_FRAC - FRAC_BITS;

  // |accel| below this counts as settled (0.01 in the speed format)
  localparam logic signed [31:0] ACCEL_EPS = 32'((((64'd1) << FRAC_BITS) + 64'd50) / 64'd100);

  // pi/30 in unsigned Q0.32
  localparam logic [31:0] RPM_TO_RAD = 32'd449767923;

  // (2^19 + 1) / 3, gives floor(x/3) exactly for x below 3 * 2^16
  localparam logic [17:0] RECIP3 = 18'd174763;

  // iteration counts of the multi-cycle units
  localparam int CNT_W       = 6;
  localparam int SQRT_STEPS  = 32;
  localparam int JDIV_STEPS  = 32;
  // divide by three of a 64-bit word, one 16-bit digit per step
  localparam int D3_STEPS    = 4;

  // register reset values
  localparam logic [30:0] SPEED_LIMIT_RST = 31'd6861947;
  localparam logic [30:0] ACCEL_LIMIT_RST = 31'd6861947;
  localparam logic [30:0] JERK_LIMIT_RST  = 31'd68619470;
  localparam logic [30:0] SETTLE_TOL_RST  = 31'd6554;
  localparam logic [31:0] TICK_PERIOD_RST = 32'd429497;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SPEED_LIMIT = 3'd0,
    CFG_ACCEL_LIMIT = 3'd1,
    CFG_JERK_LIMIT  = 3'd2,
    CFG_SETTLE_TOL  = 3'd3,
    CFG_TICK_PERIOD = 3'd4
  } cfg_idx_t;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE, ST_RPM, ST_REINIT, ST_ERR, ST_SETTLE, ST_MPROD, ST_SQLOAD, ST_SQRT,
    ST_DES, ST_JCHK, ST_JDIV, ST_JQ, ST_JDMUL, ST_JD, ST_ADT, ST_NV, ST_JD2MUL,
    ST_JD2, ST_P1, ST_P2, ST_P3LOAD, ST_D3, ST_P3, ST_FIN
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_RPM_MUL, OP_REINIT, OP_ERR, OP_SETTLE, OP_MUL_PROD,
    OP_SQRT_LOAD, OP_SQRT_STEP, OP_DES, OP_JCHK, OP_DIV_STEP, OP_JQ, OP_JD_MUL,
    OP_JD, OP_ADT, OP_NV, OP_JD2_MUL, OP_JD2, OP_P1, OP_P2, OP_P3_LOAD, OP_P3,
    OP_FIN, OP_D3_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } jlst_cmd_t;

  typedef struct packed {
    logic settle;
    logic jerk_direct;
    logic out_busy;
  } jlst_stat_t;

  // magnitude of a signed word
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return v[31] ? (32'd0 - u) : u;
  endfunction

  // put a sign back on a magnitude
  function automatic logic signed [31:0] sgn32(input logic [31:0] m, input logic neg);
    return neg ? signed'(32'd0 - m) : signed'(m);
  endfunction

  function automatic logic [63:0] sgn64(input logic [63:0] m, input logic neg);
    return neg ? (64'd0 - m) : m;
  endfunction

endpackage

// ===== hw/rtl/jlst_ifs.sv =====
interface jlst_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_speed;
  logic               reinit;
  logic signed [31:0] measured_speed_rpm;
  logic signed [31:0] measured_position;
  modport source (output valid, target_speed, reinit, measured_speed_rpm,
                  measured_position, input ready);
  modport sink   (input valid, target_speed, reinit, measured_speed_rpm,
                  measured_position, output ready);
endinterface

interface jlst_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] position_ref;
  logic signed [31:0] speed_ref;
  logic signed [31:0] accel_ref;
  logic signed [31:0] jerk_ref;
  modport source (output valid, position_ref, speed_ref, accel_ref, jerk_ref,
                  input ready);
  modport sink   (input valid, position_ref, speed_ref, accel_ref, jerk_ref,
                  output ready);
endinterface

interface jlst_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/jlst_ctrl.sv =====
module jlst_ctrl import jlst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  jlst_stat_t stat,
  output jlst_cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_RPM;
        end
      end
      ST_RPM: begin
        cmd.op    = OP_RPM_MUL;
        state_nxt = ST_REINIT;
      end
      ST_REINIT: begin
        cmd.op    = OP_REINIT;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (stat.settle) begin
          cmd.op    = OP_SETTLE;
          state_nxt = ST_FIN;
        end else begin
          cmd.op    = OP_MUL_PROD;
          state_nxt = ST_SQLOAD;
        end
      end
      ST_MPROD: begin
        cmd.op    = OP_MUL_PROD;
        state_nxt = ST_SQLOAD;
      end
      ST_SQLOAD: begin
        cmd.op    = OP_SQRT_LOAD;
        cnt_nxt   = CNT_W'(SQRT_STEPS - 1);
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DES;
        end
      end
      ST_DES: begin
        cmd.op    = OP_DES;
        state_nxt = ST_JCHK;
      end
      ST_JCHK: begin
        cmd.op = OP_JCHK;
        if (stat.jerk_direct) begin
          state_nxt = ST_JDMUL;
        end else begin
          cnt_nxt   = CNT_W'(JDIV_STEPS - 1);
          state_nxt = ST_JDIV;
        end
      end
      ST_JDIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_JQ;
        end
      end
      ST_JQ: begin
        cmd.op    = OP_JQ;
        state_nxt = ST_JDMUL;
      end
      ST_JDMUL: begin
        cmd.op    = OP_JD_MUL;
        state_nxt = ST_JD;
      end
      ST_JD: begin
        cmd.op    = OP_JD;
        state_nxt = ST_ADT;
      end
      ST_ADT: begin
        cmd.op    = OP_ADT;
        state_nxt = ST_NV;
      end
      ST_NV: begin
        cmd.op    = OP_NV;
        state_nxt = ST_JD2MUL;
      end
      ST_JD2MUL: begin
        cmd.op    = OP_JD2_MUL;
        state_nxt = ST_JD2;
      end
      ST_JD2: begin
        cmd.op    = OP_JD2;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        cmd.op    = OP_P1;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        cmd.op    = OP_P2;
        state_nxt = ST_P3LOAD;
      end
      ST_P3LOAD: begin
        cmd.op    = OP_P3_LOAD;
        cnt_nxt   = CNT_W'(D3_STEPS - 1);
        state_nxt = ST_D3;
      end
      ST_D3: begin
        cmd.op  = OP_D3_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_P3;
        end
      end
      ST_P3: begin
        cmd.op    = OP_P3;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in work");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN) |-> !stat.out_busy)
    else $error("result written over one not yet taken");

  a_d3_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P3LOAD) |=> (state_r == ST_D3 && cnt_r == CNT_W'(D3_STEPS - 1)))
    else $error("divide by three started with wrong count");
`endif

endmodule

// ===== hw/rtl/jlst_datapath.sv =====
module jlst_datapath import jlst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  jlst_cmd_t          cmd,
  output jlst_stat_t         stat,
  input  logic signed [31:0] in_target_speed,
  input  logic               in_reinit,
  input  logic signed [31:0] in_measured_speed_rpm,
  input  logic signed [31:0] in_measured_position,
  input  logic [30:0]        speed_limit,
  input  logic [30:0]        accel_limit,
  input  logic [30:0]        jerk_limit,
  input  logic [30:0]        settle_tol,
  input  logic [31:0]        tick_period,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_position_ref,
  output logic signed [31:0] out_speed_ref,
  output logic signed [31:0] out_accel_ref,
  output logic signed [31:0] out_jerk_ref
);

  localparam int F  = FRAC_BITS;
  localparam int RW = 65 - F;
  localparam int QW = 64 - F;

  // latched item
  logic signed [31:0] tgt_r, rpm_r, mpos_r;
  logic               reinit_r;
  // trajectory state
  logic signed [31:0] speed_r, accel_r;
  logic [63:0]        pos_r;
  // working registers
  logic signed [32:0] err_r, diff_r;
  logic signed [31:0] jerk_r, jd_r, adt_r, jd2_r, nv_r, na_r;
  logic [64:0]        prod_r;
  logic               mul_neg_r;
  logic [63:0]        sq_x_r, sq_res_r, sq_bit_r;
  logic [31:0]        div_rem_r, div_d_r;
  logic [63:0]        div_sh_r;
  logic               out_valid_r;

  // multiplier operand select
  logic        mul_en, mul_neg;
  logic [32:0] mul_a;
  logic [31:0] mul_b;

  always_comb begin
    mul_en  = 1'b1;
    mul_neg = 1'b0;
    mul_a   = '0;
    mul_b   = tick_period;
    case (cmd.op)
      OP_RPM_MUL: begin
        mul_a   = {1'b0, mag32(rpm_r)};
        mul_b   = RPM_TO_RAD;
        mul_neg = rpm_r[31];
      end
      OP_MUL_PROD: begin
        mul_a = (err_r[32]) ? 33'(33'd0 - err_r) : 33'(err_r);
        mul_b = {jerk_limit, 1'b0};
      end
      OP_DES: mul_a = {2'b0, jerk_limit};
      OP_JD_MUL: begin
        mul_a   = {1'b0, mag32(jerk_r)};
        mul_neg = jerk_r[31];
      end
      OP_JD: begin
        mul_a   = {1'b0, mag32(accel_r)};
        mul_neg = accel_r[31];
      end
      OP_ADT, OP_JD2_MUL: begin
        mul_a   = {1'b0, mag32(jd_r)};
        mul_neg = jd_r[31];
      end
      OP_JD2: begin
        mul_a   = {1'b0, mag32(speed_r)};
        mul_neg = speed_r[31];
      end
      OP_P1: begin
        mul_a   = {1'b0, mag32(adt_r)};
        mul_neg = adt_r[31];
      end
      OP_P2: begin
        mul_a   = {1'b0, mag32(jd2_r)};
        mul_neg = jd2_r[31];
      end
      default: mul_en = 1'b0;
    endcase
  end

  // rounded shifts of the product, ties away from zero on magnitudes
  logic [32:0]   r32, h32;
  logic [RW-1:0] r_f, h_f;
  logic [QW-1:0] q3, r3;

  assign r32 = {1'b0, prod_r[63:32]} + 33'(prod_r[31]);
  assign h32 = {2'b0, prod_r[63:33]} + 33'(prod_r[32]);
  assign r_f = {1'b0, prod_r[63:F]} + RW'(prod_r[F-1]);
  assign h_f = {2'b0, prod_r[63:F+1]} + RW'(prod_r[F]);
  // floor(p/3) shifted down by F is floor(p/(3*2^F)), its lsb is the rounding bit
  assign q3  = div_sh_r[63:F];
  assign r3  = {1'b0, q3[QW-1:1]} + QW'(q3[0]);

  // target clamp
  logic signed [32:0] ts33, vmax33, tgt_cl;
  always_comb begin
    ts33   = {in_target_speed[31], in_target_speed};
    vmax33 = {2'b0, speed_limit};
    if (ts33 > vmax33) begin
      tgt_cl = vmax33;
    end else if (ts33 < -vmax33) begin
      tgt_cl = -vmax33;
    end else begin
      tgt_cl = ts33;
    end
  end

  // error and settle test
  logic [32:0] err_abs;
  assign err_abs = err_r[32] ? 33'(33'd0 - err_r) : 33'(err_r);
  assign stat.settle = (err_abs < {2'b0, settle_tol}) && (accel_r < ACCEL_EPS) &&
                       (accel_r > -ACCEL_EPS);

  // square root step
  logic [63:0] sq_sum;
  logic        sq_ge;
  assign sq_sum = sq_res_r + sq_bit_r;
  assign sq_ge  = sq_x_r >= sq_sum;

  // acceleration aimed for and its difference
  logic [30:0]        des_mag;
  logic signed [32:0] des33, diff_nxt;
  always_comb begin
    des_mag  = (sq_res_r[32:0] < {2'b0, accel_limit}) ? sq_res_r[30:0] : accel_limit;
    des33    = err_r[32] ? -signed'({2'b0, des_mag}) : signed'({2'b0, des_mag});
    diff_nxt = des33 - {accel_r[31], accel_r};
  end

  // jerk request check
  logic [32:0]        jmag;
  logic signed [31:0] jerk_sat;
  assign jmag = diff_r[32] ? 33'(33'd0 - diff_r) : 33'(diff_r);
  assign stat.jerk_direct = (tick_period == '0) || (jmag[32:31] != 2'b00) ||
                            ({jmag[30:0], 32'b0} > prod_r[63:0]);
  assign jerk_sat = (jmag == '0) ? '0 : sgn32({1'b0, jerk_limit}, diff_r[32]);

  // divider step
  logic [32:0] div_t;
  logic        div_ge;
  assign div_t  = {div_rem_r, div_sh_r[63]};
  assign div_ge = div_t >= {1'b0, div_d_r};

  // divide by three, one 16-bit digit per step by reciprocal multiply
  logic [17:0] d3_x, d3_r;
  logic [35:0] d3_p;
  logic [15:0] d3_q;
  assign d3_x = {div_rem_r[1:0], div_sh_r[63:48]};
  assign d3_p = {18'b0, d3_x} * {18'b0, RECIP3};
  assign d3_q = d3_p[34:19];
  assign d3_r = d3_x - {1'b0, d3_q, 1'b0} - {2'b0, d3_q};

  // acceleration update and new speed
  logic signed [32:0] na33, amax33;
  logic signed [31:0] jdh;
  logic signed [33:0] nv_sum, vmax34, nv_cl, tgt34;
  logic               overshoot;
  always_comb begin
    amax33 = {2'b0, accel_limit};
    na33   = {accel_r[31], accel_r} + {jd_r[31], jd_r};
    if (na33 > amax33) begin
      na33 = amax33;
    end else if (na33 < -amax33) begin
      na33 = -amax33;
    end
    jdh    = sgn32(h32[31:0], mul_neg_r);
    nv_sum = {{2{speed_r[31]}}, speed_r} + {{2{adt_r[31]}}, adt_r} + {{2{jdh[31]}}, jdh};
    vmax34 = {3'b0, speed_limit};
    if (nv_sum > vmax34) begin
      nv_cl = vmax34;
    end else if (nv_sum < -vmax34) begin
      nv_cl = -vmax34;
    end else begin
      nv_cl = nv_sum;
    end
    tgt34     = {{2{tgt_r[31]}}, tgt_r};
    overshoot = (!err_r[32] && nv_cl > tgt34) || (err_r[32] && nv_cl < tgt34);
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r    <= {32'b0, mul_a} * {33'b0, mul_b};
      mul_neg_r <= mul_neg;
    end
  end

  // trajectory state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
      accel_r <= '0;
      pos_r   <= '0;
    end else begin
      case (cmd.op)
        OP_REINIT: begin
          if (reinit_r) begin
            speed_r <= sgn32(r32[31:0], mul_neg_r);
            accel_r <= '0;
            pos_r   <= {{32{mpos_r[31]}}, mpos_r} << POS_SHIFT;
          end
        end
        OP_P1:  pos_r <= pos_r + sgn64(64'(r_f), mul_neg_r);
        OP_P2:  pos_r <= pos_r + sgn64(64'(h_f), mul_neg_r);
        OP_P3:  pos_r <= pos_r + sgn64(64'(r3), mul_neg_r);
        OP_FIN: begin
          speed_r <= nv_r;
          accel_r <= na_r;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        tgt_r    <= tgt_cl[31:0];
        reinit_r <= in_reinit;
        rpm_r    <= in_measured_speed_rpm;
        mpos_r   <= in_measured_position;
      end
      OP_ERR: err_r <= {tgt_r[31], tgt_r} - {speed_r[31], speed_r};
      OP_SETTLE: begin
        nv_r   <= tgt_r;
        na_r   <= '0;
        jerk_r <= '0;
      end
      OP_SQRT_LOAD: begin
        sq_x_r   <= prod_r[63:0];
        sq_res_r <= '0;
        sq_bit_r <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_x_r   <= sq_x_r - sq_sum;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_DES: diff_r <= diff_nxt;
      OP_JCHK: begin
        jerk_r    <= jerk_sat;
        div_rem_r <= jmag[31:0];
        div_sh_r  <= '0;
        div_d_r   <= tick_period;
      end
      OP_DIV_STEP: begin
        div_rem_r <= div_ge ? 32'(div_t - {1'b0, div_d_r}) : div_t[31:0];
        div_sh_r  <= {div_sh_r[62:0], div_ge};
      end
      OP_JQ: jerk_r <= sgn32(div_sh_r[31:0], diff_r[32]);
      OP_JD: jd_r <= sgn32(r32[31:0], mul_neg_r);
      OP_ADT: begin
        adt_r <= sgn32(r32[31:0], mul_neg_r);
        na_r  <= na33[31:0];
      end
      OP_NV: begin
        if (overshoot) begin
          nv_r   <= tgt_r;
          na_r   <= '0;
          jerk_r <= '0;
          jd_r   <= '0;
        end else begin
          nv_r <= nv_cl[31:0];
        end
      end
      OP_JD2: jd2_r <= sgn32(r32[31:0], mul_neg_r);
      OP_P3_LOAD: begin
        div_rem_r <= '0;
        div_sh_r  <= prod_r[63:0];
      end
      OP_D3_STEP: begin
        div_rem_r <= {30'b0, d3_r[1:0]};
        div_sh_r  <= {div_sh_r[47:0], d3_q};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      out_position_ref <= pos_r;
      out_speed_ref    <= nv_r;
      out_accel_ref    <= na_r;
      out_jerk_ref     <= jerk_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

// ===== hw/rtl/jerk_limited_speed_trajectory_core.sv =====
// channel | role   | payload
// in_ch   | sink   | target_speed, reinit, measured_speed_rpm, measured_position
// out_ch  | source | position_ref, speed_ref, accel_ref, jerk_ref
// cfg_ch  | sink   | index, data (always ready)
//
// one item at a time; a settling item skips the long steps, a moving one runs
// the square root and the divide by three, and the jerk divide only when the jerk request needs it;
// the bit-serial square root (32 steps), the shared divider (32 steps for the jerk
// quotient) and the divide by three (4 digit steps) are those long steps
// a finished result waits in the output register while the next item is taken;
// the next result stalls until that one is taken
// synchronous active-low reset clears state, limits go to their defaults
module jerk_limited_speed_trajectory_core import jlst_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  jlst_in_if.sink   in_ch,
  jlst_out_if.source out_ch,
  jlst_cfg_if.sink  cfg_ch
);

  logic [30:0] speed_limit_r, accel_limit_r, jerk_limit_r, settle_tol_r;
  logic [31:0] tick_period_r;
  jlst_cmd_t   cmd;
  jlst_stat_t  stat;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= SPEED_LIMIT_RST;
      accel_limit_r <= ACCEL_LIMIT_RST;
      jerk_limit_r  <= JERK_LIMIT_RST;
      settle_tol_r  <= SETTLE_TOL_RST;
      tick_period_r <= TICK_PERIOD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_SPEED_LIMIT: speed_limit_r <= cfg_ch.data[30:0];
        CFG_ACCEL_LIMIT: accel_limit_r <= cfg_ch.data[30:0];
        CFG_JERK_LIMIT:  jerk_limit_r  <= cfg_ch.data[30:0];
        CFG_SETTLE_TOL:  settle_tol_r  <= cfg_ch.data[30:0];
        CFG_TICK_PERIOD: tick_period_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequencer
  jlst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and state
  jlst_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_target_speed       (in_ch.target_speed),
    .in_reinit             (in_ch.reinit),
    .in_measured_speed_rpm (in_ch.measured_speed_rpm),
    .in_measured_position  (in_ch.measured_position),
    .speed_limit           (speed_limit_r),
    .accel_limit           (accel_limit_r),
    .jerk_limit            (jerk_limit_r),
    .settle_tol            (settle_tol_r),
    .tick_period           (tick_period_r),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_position_ref      (out_ch.position_ref),
    .out_speed_ref         (out_ch.speed_ref),
    .out_accel_ref         (out_ch.accel_ref),
    .out_jerk_ref          (out_ch.jerk_ref)
  );

endmodule
